FILE: hdl/hysteresis_relay_zone_controller_defines.svh
// assertion macros for the relay zone controller
// used by the top level only, no other dependencies
`ifndef HYSTERESIS_RELAY_ZONE_CONTROLLER_DEFINES_SVH
`define HYSTERESIS_RELAY_ZONE_CONTROLLER_DEFINES_SVH
`ifndef SYNTHESIS
// clocked check, off while reset is held
`define HRZC_ASSERT_RST(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("relay zone controller check failed");
// clocked check, live during reset too
`define HRZC_ASSERT_ALL(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("relay zone controller check failed");
`else
`define HRZC_ASSERT_RST(label, clk, rst_n, prop)
`define HRZC_ASSERT_ALL(label, clk, prop)
`endif
`endif

FILE: hdl/hrzc_pkg.sv
// shared types, codes and reset values of the relay zone controller
// no dependencies
`timescale 1ns / 1ps
package hrzc_pkg;

  localparam int TEMP_W = 12;
  localparam int HUM_W  = 10;
  localparam int HYST_W = 9;
  localparam int MINH_W = 7;
  localparam int MS_W   = 20;
  localparam int ERR_W  = 16;
  localparam int STK_W  = 8;
  localparam int OPC_W  = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  // opcodes on the input channel
  localparam logic [OPC_W-1:0] OP_SAMPLE       = 4'd0;
  localparam logic [OPC_W-1:0] OP_SENSOR_ERROR = 4'd1;
  localparam logic [OPC_W-1:0] OP_EVALUATE     = 4'd2;
  localparam logic [OPC_W-1:0] OP_SET_MANUAL   = 4'd3;
  localparam logic [OPC_W-1:0] OP_SET_FORCEOFF = 4'd4;
  localparam logic [OPC_W-1:0] OP_FAILSAFE_ON  = 4'd5;
  localparam logic [OPC_W-1:0] OP_FAILSAFE_OFF = 4'd6;
  localparam logic [OPC_W-1:0] OP_EMERGENCY    = 4'd7;
  localparam logic [OPC_W-1:0] OP_TICK         = 4'd8;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_THR   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HUM_THR    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_HYST  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HUM_HYST   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_T_HYST = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_H_HYST = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_SW_MS  = 3'd6;

  // register reset values
  localparam logic [TEMP_W-1:0] RST_TEMP_THR   = 12'd300;
  localparam logic [HUM_W-1:0]  RST_HUM_THR    = 10'd700;
  localparam logic [HYST_W-1:0] RST_TEMP_HYST  = 9'd10;
  localparam logic [HYST_W-1:0] RST_HUM_HYST   = 9'd50;
  localparam logic [MINH_W-1:0] RST_MIN_T_HYST = 7'd5;
  localparam logic [MINH_W-1:0] RST_MIN_H_HYST = 7'd20;
  localparam logic [MS_W-1:0]   RST_MIN_SW_MS  = 20'd60000;

  // decoded command kinds
  localparam logic [3:0] K_NONE     = 4'd0;
  localparam logic [3:0] K_SAMPLE   = 4'd1;
  localparam logic [3:0] K_SENS_ERR = 4'd2;
  localparam logic [3:0] K_EVAL     = 4'd3;
  localparam logic [3:0] K_SET_MAN  = 4'd4;
  localparam logic [3:0] K_SET_FO   = 4'd5;
  localparam logic [3:0] K_FS_ON    = 4'd6;
  localparam logic [3:0] K_FS_OFF   = 4'd7;
  localparam logic [3:0] K_EMERG    = 4'd8;
  localparam logic [3:0] K_TICK     = 4'd9;

  typedef struct packed {
    logic [3:0]        kind;
    logic [TEMP_W-1:0] temp;
    logic [HUM_W-1:0]  hum;
    logic              flag;
    logic              force_imm;
    logic              sense;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic not_empty;
  } q_stat_t;

endpackage

FILE: hdl/hrzc_ifs.sv
// channel interfaces: command input, status output, register write
// depends on hrzc_pkg
`timescale 1ns / 1ps
interface hrzc_in_if;
  logic                      valid;
  logic                      ready;
  logic [hrzc_pkg::OPC_W-1:0]  opcode;
  logic signed [hrzc_pkg::TEMP_W-1:0] temp_sample;
  logic [hrzc_pkg::HUM_W-1:0]  hum_sample;
  logic                      flag_value;
  logic                      force_immediate;
  logic                      relay_sense;
  modport source (output valid, opcode, temp_sample, hum_sample, flag_value,
                  force_immediate, relay_sense, input ready);
  modport sink (input valid, opcode, temp_sample, hum_sample, flag_value,
                force_immediate, relay_sense, output ready);
endinterface

interface hrzc_out_if;
  logic                      valid;
  logic                      ready;
  logic                      relay_on;
  logic                      relay_level;
  logic                      failsafe_active;
  logic                      manual_active;
  logic                      force_off_active;
  logic                      reading_valid;
  logic [hrzc_pkg::ERR_W-1:0]  error_count;
  logic [hrzc_pkg::STK_W-1:0]  stuck_count;
  logic                      switch_suppressed;
  logic signed [hrzc_pkg::TEMP_W-1:0] temp_now;
  logic [hrzc_pkg::HUM_W-1:0]  hum_now;
  modport source (output valid, relay_on, relay_level, failsafe_active, manual_active,
                  force_off_active, reading_valid, error_count, stuck_count,
                  switch_suppressed, temp_now, hum_now, input ready);
  modport sink (input valid, relay_on, relay_level, failsafe_active, manual_active,
                force_off_active, reading_valid, error_count, stuck_count,
                switch_suppressed, temp_now, hum_now, output ready);
endinterface

interface hrzc_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [hrzc_pkg::CFG_IDX_W-1:0]  index;
  logic [hrzc_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: hdl/hrzc_front.sv
// front end: takes command transfers and decodes the opcode into a command
// depends on hrzc_pkg and hrzc_ifs
`timescale 1ns / 1ps
module hrzc_front (
  hrzc_in_if.sink           in_if,
  input  hrzc_pkg::q_stat_t q_stat,
  output logic              push,
  output hrzc_pkg::cmd_t    push_cmd
);
  import hrzc_pkg::*;

  logic [3:0] kind;

  always_comb begin
    case (in_if.opcode)
      OP_SAMPLE:       kind = K_SAMPLE;
      OP_SENSOR_ERROR: kind = K_SENS_ERR;
      OP_EVALUATE:     kind = K_EVAL;
      OP_SET_MANUAL:   kind = K_SET_MAN;
      OP_SET_FORCEOFF: kind = K_SET_FO;
      OP_FAILSAFE_ON:  kind = K_FS_ON;
      OP_FAILSAFE_OFF: kind = K_FS_OFF;
      OP_EMERGENCY:    kind = K_EMERG;
      OP_TICK:         kind = K_TICK;
      default:         kind = K_NONE;
    endcase
  end

  assign in_if.ready = !q_stat.full;
  assign push        = in_if.valid && !q_stat.full;

  assign push_cmd.kind      = kind;
  assign push_cmd.temp      = in_if.temp_sample;
  assign push_cmd.hum       = in_if.hum_sample;
  assign push_cmd.flag      = in_if.flag_value;
  assign push_cmd.force_imm = in_if.force_immediate;
  assign push_cmd.sense     = in_if.relay_sense;

endmodule

FILE: hdl/hrzc_queue.sv
// two-entry command queue between front and back end
// depends on hrzc_pkg
`timescale 1ns / 1ps
module hrzc_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  hrzc_pkg::cmd_t    push_cmd,
  input  logic              pop,
  output hrzc_pkg::cmd_t    head_cmd,
  output hrzc_pkg::q_stat_t q_stat
);
  import hrzc_pkg::*;

  cmd_t       slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  assign head_cmd         = slot_r[rd_ptr_r];
  assign q_stat.full      = count_r[1];
  assign q_stat.not_empty = (count_r != 2'd0);

endmodule

FILE: hdl/hrzc_back.sv
// back end: config registers, controller state and the status output register
// depends on hrzc_pkg and hrzc_ifs
`timescale 1ns / 1ps
module hrzc_back (
  input  logic              clk,
  input  logic              rst_n,
  hrzc_cfg_if.sink          cfg_if,
  input  hrzc_pkg::q_stat_t q_stat,
  input  hrzc_pkg::cmd_t    head_cmd,
  output logic              pop,
  hrzc_out_if.source        out_if
);
  import hrzc_pkg::*;

  // configuration
  logic [TEMP_W-1:0] temp_thr_r;
  logic [HUM_W-1:0]  hum_thr_r;
  logic [HYST_W-1:0] temp_hyst_r;
  logic [HYST_W-1:0] hum_hyst_r;
  logic [MINH_W-1:0] min_t_hyst_r;
  logic [MINH_W-1:0] min_h_hyst_r;
  logic [MS_W-1:0]   min_sw_ms_r;

  // controller state
  logic              relay_r, relay_nxt;
  logic              manual_r, manual_nxt;
  logic              forceoff_r, forceoff_nxt;
  logic              failsafe_r, failsafe_nxt;
  logic              seen_r, seen_nxt;
  logic [TEMP_W-1:0] temp_r, temp_nxt;
  logic [HUM_W-1:0]  hum_r, hum_nxt;
  logic [ERR_W-1:0]  err_r, err_nxt;
  logic [STK_W-1:0]  stuck_r, stuck_nxt;
  logic [MS_W-1:0]   ms_r, ms_nxt;
  logic              switched_r, switched_nxt;
  logic              supp_nxt;

  // output register
  logic              out_valid_r;
  logic              res_supp_r;

  // evaluate datapath
  logic [HYST_W-1:0]        ht, hh;
  logic signed [TEMP_W+1:0] temp_lo;
  logic signed [HUM_W+1:0]  hum_lo;
  logic                     hold_on, reach_on, auto_on, desired, relay_eval;

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_thr_r   <= RST_TEMP_THR;
      hum_thr_r    <= RST_HUM_THR;
      temp_hyst_r  <= RST_TEMP_HYST;
      hum_hyst_r   <= RST_HUM_HYST;
      min_t_hyst_r <= RST_MIN_T_HYST;
      min_h_hyst_r <= RST_MIN_H_HYST;
      min_sw_ms_r  <= RST_MIN_SW_MS;
    end else if (cfg_if.valid) begin
      case (cfg_if.index)
        REG_TEMP_THR:   temp_thr_r   <= cfg_if.data[TEMP_W-1:0];
        REG_HUM_THR:    hum_thr_r    <= cfg_if.data[HUM_W-1:0];
        REG_TEMP_HYST:  temp_hyst_r  <= cfg_if.data[HYST_W-1:0];
        REG_HUM_HYST:   hum_hyst_r   <= cfg_if.data[HYST_W-1:0];
        REG_MIN_T_HYST: min_t_hyst_r <= cfg_if.data[MINH_W-1:0];
        REG_MIN_H_HYST: min_h_hyst_r <= cfg_if.data[MINH_W-1:0];
        REG_MIN_SW_MS:  min_sw_ms_r  <= cfg_if.data[MS_W-1:0];
        default: ;
      endcase
    end
  end

  // effective bands and threshold compares
  always_comb begin
    ht = (temp_hyst_r < {2'b00, min_t_hyst_r}) ? {2'b00, min_t_hyst_r} : temp_hyst_r;
    hh = (hum_hyst_r < {2'b00, min_h_hyst_r}) ? {2'b00, min_h_hyst_r} : hum_hyst_r;
    temp_lo = $signed({{2{temp_thr_r[TEMP_W-1]}}, temp_thr_r}) - $signed({5'b0, ht});
    hum_lo  = $signed({2'b00, hum_thr_r}) - $signed({3'b000, hh});
    hold_on = ($signed({{2{temp_r[TEMP_W-1]}}, temp_r}) >= temp_lo)
           || ($signed({2'b00, hum_r}) >= hum_lo);
    reach_on = ($signed(temp_r) >= $signed(temp_thr_r)) || (hum_r >= hum_thr_r);
    auto_on  = seen_r && (relay_r ? hold_on : reach_on);
    desired  = auto_on || manual_r;
  end

  assign pop = q_stat.not_empty && (!out_valid_r || out_if.ready);

  always_comb begin
    relay_nxt    = relay_r;
    manual_nxt   = manual_r;
    forceoff_nxt = forceoff_r;
    failsafe_nxt = failsafe_r;
    seen_nxt     = seen_r;
    temp_nxt     = temp_r;
    hum_nxt      = hum_r;
    err_nxt      = err_r;
    stuck_nxt    = stuck_r;
    ms_nxt       = ms_r;
    switched_nxt = switched_r;
    supp_nxt     = 1'b0;
    relay_eval   = relay_r;
    case (head_cmd.kind)
      K_SAMPLE: begin
        temp_nxt = head_cmd.temp;
        hum_nxt  = head_cmd.hum;
        seen_nxt = 1'b1;
        err_nxt  = '0;
      end
      K_SENS_ERR: begin
        if (err_r != '1) err_nxt = err_r + 1'b1;
      end
      K_EVAL: begin
        if (failsafe_r || forceoff_r) begin
          relay_nxt = 1'b0;
        end else begin
          if (desired != relay_r) begin
            if (!(manual_r || head_cmd.force_imm) && switched_r && (ms_r < min_sw_ms_r)) begin
              supp_nxt = 1'b1;
            end else begin
              relay_eval   = desired;
              ms_nxt       = '0;
              switched_nxt = 1'b1;
            end
          end
          relay_nxt = relay_eval;
          // drive is active low: a sensed level equal to the relay state is a mismatch
          if (head_cmd.sense == relay_eval) begin
            if (stuck_r != '1) stuck_nxt = stuck_r + 1'b1;
          end else begin
            stuck_nxt = '0;
          end
        end
      end
      K_SET_MAN: manual_nxt = head_cmd.flag;
      K_SET_FO:  forceoff_nxt = head_cmd.flag;
      K_FS_ON: begin
        failsafe_nxt = 1'b1;
        relay_nxt    = 1'b0;
      end
      K_FS_OFF: failsafe_nxt = 1'b0;
      K_EMERG: begin
        relay_nxt    = 1'b0;
        manual_nxt   = 1'b0;
        forceoff_nxt = 1'b0;
        failsafe_nxt = 1'b0;
      end
      K_TICK: begin
        if (ms_r != '1) ms_nxt = ms_r + 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      relay_r     <= 1'b0;
      manual_r    <= 1'b0;
      forceoff_r  <= 1'b0;
      failsafe_r  <= 1'b0;
      seen_r      <= 1'b0;
      temp_r      <= '0;
      hum_r       <= '0;
      err_r       <= '0;
      stuck_r     <= '0;
      ms_r        <= '0;
      switched_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        relay_r    <= relay_nxt;
        manual_r   <= manual_nxt;
        forceoff_r <= forceoff_nxt;
        failsafe_r <= failsafe_nxt;
        seen_r     <= seen_nxt;
        temp_r     <= temp_nxt;
        hum_r      <= hum_nxt;
        err_r      <= err_nxt;
        stuck_r    <= stuck_nxt;
        ms_r       <= ms_nxt;
        switched_r <= switched_nxt;
      end
      if (pop) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res_supp_r <= supp_nxt;
    end
  end

  // status fields come straight from the state, which only moves on a pop
  assign out_if.valid             = out_valid_r;
  assign out_if.relay_on          = relay_r;
  assign out_if.relay_level       = !relay_r;
  assign out_if.failsafe_active   = failsafe_r;
  assign out_if.manual_active     = manual_r;
  assign out_if.force_off_active  = forceoff_r;
  assign out_if.reading_valid     = seen_r;
  assign out_if.error_count       = err_r;
  assign out_if.stuck_count       = stuck_r;
  assign out_if.switch_suppressed = res_supp_r;
  assign out_if.temp_now          = temp_r;
  assign out_if.hum_now           = hum_r;

endmodule

FILE: hdl/hysteresis_relay_zone_controller.sv
// top level of the relay zone controller: front decode, command queue, back end
// depends on hrzc_pkg, hrzc_ifs, hrzc_front, hrzc_queue, hrzc_back and the defines header
`timescale 1ns / 1ps
`include "hysteresis_relay_zone_controller_defines.svh"
// Drives one active-low relay from stored temperature and humidity samples with
// dual-threshold hysteresis and a minimum time between automatic switches.
// Every command transfer on in_if produces exactly one status transfer on out_if.
// Throughput is one command per clock, sustained, as long as out_if takes results;
// that figure is set by the back end, which updates its whole state on a single pop.
// From input transfer to result valid, the transfer writes the command into the
// two-entry queue, and a pop then carries it through the back end into the status
// register, from which the result transfers on out_if.
// A stalled output lets up to two more commands pile up in the queue before
// in_if.ready drops. Register writes on cfg_if are always taken (ready stays
// high) and are meant to happen only while no command is in flight.
module hysteresis_relay_zone_controller (
  input  logic      clk,
  input  logic      rst_n,
  hrzc_in_if.sink   in_if,
  hrzc_cfg_if.sink  cfg_if,
  hrzc_out_if.source out_if
);
  import hrzc_pkg::*;

  // front to queue
  logic    push;
  cmd_t    push_cmd;
  // queue to back end
  cmd_t    head_cmd;
  logic    pop;
  q_stat_t q_stat;

  // opcode decode, backpressure from queue fill
  hrzc_front u_front (
    .in_if    (in_if),
    .q_stat   (q_stat),
    .push     (push),
    .push_cmd (push_cmd)
  );

  // decouples decode from execution so each side stalls on its own
  hrzc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head_cmd (head_cmd),
    .q_stat   (q_stat)
  );

  // register file, hysteresis decision, counters and the status register
  hrzc_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_if   (cfg_if),
    .q_stat   (q_stat),
    .head_cmd (head_cmd),
    .pop      (pop),
    .out_if   (out_if)
  );

  // an accepted transfer is always waiting in the queue on the next cycle
  `HRZC_ASSERT_RST(a_push_lands, clk, rst_n, (in_if.valid && in_if.ready) |=> q_stat.not_empty)
  // failsafe never reports the relay on
  `HRZC_ASSERT_RST(a_failsafe_off, clk, rst_n,
                   (out_if.valid && out_if.failsafe_active) |-> !out_if.relay_on)
  // suppression only happens on the automatic path
  `HRZC_ASSERT_RST(a_supp_auto, clk, rst_n,
                   (out_if.valid && out_if.switch_suppressed) |->
                   (!out_if.failsafe_active && !out_if.force_off_active &&
                    !out_if.manual_active))
  // nothing is popped from an empty queue
  `HRZC_ASSERT_ALL(a_pop_nonempty, clk, pop |-> q_stat.not_empty)

endmodule

FILE: sim/hysteresis_relay_zone_controller_tb.sv
// self-checking bench for the relay zone controller: directed and random commands,
// a prediction of the contents of every status transfer, and random idling on both channels
// depends on hrzc_pkg, hrzc_ifs and the hysteresis_relay_zone_controller rtl
`timescale 1ns / 1ps
module hysteresis_relay_zone_controller_tb;
  import hrzc_pkg::*;

  // opcodes with no function, the block only reports status for them
  localparam logic [OPC_W-1:0] OPC_FIRST_UNUSED = 4'd9;
  localparam logic [OPC_W-1:0] OPC_LAST_UNUSED  = 4'd15;

  localparam int STUCK_MAX   = 255;
  localparam int ERR_MAX     = 65535;
  localparam int MS_MAX      = 1048575;
  localparam int CYCLE_LIMIT = 5000000;
  localparam int ITEMS_PER_PHASE = 140;

  // one command as the bench sees it
  typedef struct packed {
    logic [OPC_W-1:0]         opcode;
    logic signed [TEMP_W-1:0] temp;
    logic [HUM_W-1:0]         hum;
    logic                     flag;
    logic                     force_imm;
    logic                     sense;
  } zone_cmd_t;

  // one status word, field for field as on out_if
  typedef struct packed {
    logic                     relay_on;
    logic                     relay_level;
    logic                     failsafe_active;
    logic                     manual_active;
    logic                     force_off_active;
    logic                     reading_valid;
    logic [ERR_W-1:0]         error_count;
    logic [STK_W-1:0]         stuck_count;
    logic                     switch_suppressed;
    logic signed [TEMP_W-1:0] temp_now;
    logic [HUM_W-1:0]         hum_now;
  } zone_status_t;

  logic clk = 1'b0;
  logic rst_n;

  hrzc_in_if  in_bus();
  hrzc_out_if out_bus();
  hrzc_cfg_if cfg_bus();

  hysteresis_relay_zone_controller DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_bus),
    .cfg_if (cfg_bus),
    .out_if (out_bus)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // predicted controller: register copy and zone state
  // ---------------------------------------------------------------------------
  logic signed [TEMP_W-1:0] thr_temp;
  logic [HUM_W-1:0]         thr_hum;
  logic [HYST_W-1:0]        hyst_temp;
  logic [HYST_W-1:0]        hyst_hum;
  logic [MINH_W-1:0]        min_hyst_temp;
  logic [MINH_W-1:0]        min_hyst_hum;
  logic [MS_W-1:0]          min_switch_ms;

  logic                     relay;
  logic                     manual;
  logic                     forceoff;
  logic                     failsafe;
  logic                     seen_sample;
  logic signed [TEMP_W-1:0] temp_held;
  logic [HUM_W-1:0]         hum_held;
  logic [ERR_W-1:0]         sensor_errs;
  logic [STK_W-1:0]         stuck_run;
  logic [MS_W-1:0]          ms_since_switch;
  logic                     has_switched;

  zone_cmd_t    cmd_q[$];     // commands waiting for the driver
  zone_status_t status_q[$];  // status words owed by the block, oldest first
  int           fail_cnt = 0;
  logic         cfg_junk;     // put random bits above a register's width

  // apply one accepted command to the predicted state, return the status it owes
  function automatic zone_status_t next_status(input zone_cmd_t c);
    zone_status_t s;
    int           band_t;
    int           band_h;
    int           t_now;
    int           h_now;
    logic         auto_on;
    logic         desired;
    logic         suppressed;
    suppressed = 1'b0;
    case (c.opcode)
      OP_SAMPLE: begin
        temp_held   = c.temp;
        hum_held    = c.hum;
        seen_sample = 1'b1;
        sensor_errs = '0;
      end
      OP_SENSOR_ERROR: begin
        if (sensor_errs != ERR_W'(ERR_MAX)) sensor_errs = sensor_errs + 1'b1;
      end
      OP_EVALUATE: begin
        if (failsafe || forceoff) begin
          // early exit: relay off, timer and stuck check untouched
          relay = 1'b0;
        end else begin
          band_t = (hyst_temp < min_hyst_temp) ? int'(min_hyst_temp) : int'(hyst_temp);
          band_h = (hyst_hum < min_hyst_hum) ? int'(min_hyst_hum) : int'(hyst_hum);
          t_now  = int'(temp_held);
          h_now  = int'(hum_held);
          if (!seen_sample) begin
            auto_on = 1'b0;
          end else if (relay) begin
            auto_on = (t_now >= int'(thr_temp) - band_t) || (h_now >= int'(thr_hum) - band_h);
          end else begin
            auto_on = (t_now >= int'(thr_temp)) || (h_now >= int'(thr_hum));
          end
          desired = auto_on || manual;
          if (desired != relay) begin
            if (!(manual || c.force_imm) && has_switched && ms_since_switch < min_switch_ms)
            begin
              suppressed = 1'b1;
            end else begin
              relay           = desired;
              ms_since_switch = '0;
              has_switched    = 1'b1;
            end
          end
          // drive is active low, sense should read back the inverse of relay
          if (c.sense != !relay) begin
            if (stuck_run != STK_W'(STUCK_MAX)) stuck_run = stuck_run + 1'b1;
          end else begin
            stuck_run = '0;
          end
        end
      end
      OP_SET_MANUAL:   manual = c.flag;
      OP_SET_FORCEOFF: forceoff = c.flag;
      OP_FAILSAFE_ON: begin
        failsafe = 1'b1;
        relay    = 1'b0;
      end
      OP_FAILSAFE_OFF: failsafe = 1'b0;
      OP_EMERGENCY: begin
        relay    = 1'b0;
        manual   = 1'b0;
        forceoff = 1'b0;
        failsafe = 1'b0;
      end
      OP_TICK: begin
        if (ms_since_switch != MS_W'(MS_MAX)) ms_since_switch = ms_since_switch + 1'b1;
      end
      default: ;
    endcase
    s.relay_on          = relay;
    s.relay_level       = !relay;
    s.failsafe_active   = failsafe;
    s.manual_active     = manual;
    s.force_off_active  = forceoff;
    s.reading_valid     = seen_sample;
    s.error_count       = sensor_errs;
    s.stuck_count       = stuck_run;
    s.switch_suppressed = suppressed;
    s.temp_now          = temp_held;
    s.hum_now           = hum_held;
    return s;
  endfunction

  // ---------------------------------------------------------------------------
  // command builders
  // ---------------------------------------------------------------------------
  function automatic zone_cmd_t make_cmd(input logic [OPC_W-1:0] op,
                                         input logic signed [TEMP_W-1:0] t,
                                         input logic [HUM_W-1:0] h, input logic f,
                                         input logic fi, input logic s);
    zone_cmd_t c;
    c.opcode    = op;
    c.temp      = t;
    c.hum       = h;
    c.flag      = f;
    c.force_imm = fi;
    c.sense     = s;
    return c;
  endfunction

  // every field random, the caller fixes what matters
  function automatic zone_cmd_t noisy_cmd(input logic [OPC_W-1:0] op);
    return make_cmd(op, TEMP_W'($urandom), HUM_W'($urandom), 1'($urandom),
                    1'($urandom), 1'($urandom));
  endfunction

  // mostly around the thresholds and the hysteresis band, sometimes any bit pattern
  function automatic zone_cmd_t sample_cmd();
    zone_cmd_t c;
    int        span_t;
    int        span_h;
    c = noisy_cmd(OP_SAMPLE);
    if ($urandom_range(0, 4) != 0) begin
      span_t = int'(hyst_temp) + int'(min_hyst_temp) + 4;
      span_h = int'(hyst_hum) + int'(min_hyst_hum) + 4;
      c.temp = TEMP_W'(int'(thr_temp) - span_t + int'($urandom_range(0, 2 * span_t)));
      c.hum  = HUM_W'(int'(thr_hum) - span_h + int'($urandom_range(0, 2 * span_h)));
    end
    return c;
  endfunction

  // random phase: mostly sample / time / evaluate episodes, the rest loose commands
  task automatic queue_random_phase(input int count);
    int        n;
    int        pick;
    int        reps;
    zone_cmd_t c;
    n = 0;
    while (n < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        cmd_q.push_back(sample_cmd());
        reps = $urandom_range(0, 12);
        repeat (reps) cmd_q.push_back(noisy_cmd(OP_TICK));
        c = noisy_cmd(OP_EVALUATE);
        c.force_imm = ($urandom_range(0, 99) < 15);
        cmd_q.push_back(c);
        n += reps + 2;
      end else if (pick < 50) begin
        reps = $urandom_range(1, 20);
        repeat (reps) cmd_q.push_back(noisy_cmd(OP_TICK));
        n += reps;
      end else if (pick < 62) begin
        c = noisy_cmd(OP_EVALUATE);
        c.force_imm = ($urandom_range(0, 99) < 15);
        cmd_q.push_back(c);
        n++;
      end else begin
        if (pick < 70)      c = noisy_cmd(OP_SENSOR_ERROR);
        else if (pick < 77) c = noisy_cmd(OP_SET_MANUAL);
        else if (pick < 83) c = noisy_cmd(OP_SET_FORCEOFF);
        else if (pick < 87) c = noisy_cmd(OP_FAILSAFE_ON);
        else if (pick < 92) c = noisy_cmd(OP_FAILSAFE_OFF);
        else if (pick < 95) c = noisy_cmd(OP_EMERGENCY);
        else if (pick < 98) c = noisy_cmd(OPC_W'($urandom_range(OPC_FIRST_UNUSED,
                                                                OPC_LAST_UNUSED)));
        else                c = sample_cmd();
        cmd_q.push_back(c);
        n++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // register writes, only while nothing is in flight
  // ---------------------------------------------------------------------------
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value, input int width);
    logic [CFG_DATA_W-1:0] data;
    data = value;
    // bits above the register width must be dropped by the block
    if (cfg_junk && width < CFG_DATA_W) data = data | (CFG_DATA_W'($urandom) << width);
    @(posedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= data;
    do @(posedge clk); while (!cfg_bus.ready);
    case (idx)
      REG_TEMP_THR:   thr_temp      = data[TEMP_W-1:0];
      REG_HUM_THR:    thr_hum       = data[HUM_W-1:0];
      REG_TEMP_HYST:  hyst_temp     = data[HYST_W-1:0];
      REG_HUM_HYST:   hyst_hum      = data[HYST_W-1:0];
      REG_MIN_T_HYST: min_hyst_temp = data[MINH_W-1:0];
      REG_MIN_H_HYST: min_hyst_hum  = data[MINH_W-1:0];
      REG_MIN_SW_MS:  min_switch_ms = data[MS_W-1:0];
      default: ;
    endcase
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic program_setting(input logic signed [TEMP_W-1:0] t_thr,
                                 input logic [HUM_W-1:0] h_thr,
                                 input logic [HYST_W-1:0] t_hy, input logic [HYST_W-1:0] h_hy,
                                 input logic [MINH_W-1:0] t_min,
                                 input logic [MINH_W-1:0] h_min,
                                 input logic [MS_W-1:0] sw_ms);
    cfg_junk = 1'($urandom_range(0, 1));
    write_reg(REG_TEMP_THR,   CFG_DATA_W'({t_thr}), TEMP_W);
    write_reg(REG_HUM_THR,    CFG_DATA_W'(h_thr), HUM_W);
    write_reg(REG_TEMP_HYST,  CFG_DATA_W'(t_hy), HYST_W);
    write_reg(REG_HUM_HYST,   CFG_DATA_W'(h_hy), HYST_W);
    write_reg(REG_MIN_T_HYST, CFG_DATA_W'(t_min), MINH_W);
    write_reg(REG_MIN_H_HYST, CFG_DATA_W'(h_min), MINH_W);
    write_reg(REG_MIN_SW_MS,  sw_ms, MS_W);
  endtask

  // idle means: nothing queued, nothing offered, nothing owed
  task automatic wait_drained();
    do @(negedge clk); while (cmd_q.size() != 0 || in_bus.valid || status_q.size() != 0);
  endtask

  // ---------------------------------------------------------------------------
  // command driver: bursts of random length with random gaps between them
  // ---------------------------------------------------------------------------
  zone_cmd_t cur_cmd;
  int        burst_left = 1;
  int        gap_left   = 0;

  always @(posedge clk) begin : cmd_driver
    logic offer;
    if (!rst_n) begin
      in_bus.valid           <= 1'b0;
      in_bus.opcode          <= OP_SAMPLE;
      in_bus.temp_sample     <= '0;
      in_bus.hum_sample      <= '0;
      in_bus.flag_value      <= 1'b0;
      in_bus.force_immediate <= 1'b0;
      in_bus.relay_sense     <= 1'b0;
    end else begin
      // transfer at this edge: the command on the bus is now owed a status word
      if (in_bus.valid && in_bus.ready) status_q.push_back(next_status(cur_cmd));
      if (!in_bus.valid || in_bus.ready) begin
        offer = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (cmd_q.size() > 0) begin
          cur_cmd = cmd_q.pop_front();
          offer   = 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            // a third of the bursts follow on with no gap at all
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left--;
          end
        end
        in_bus.valid <= offer;
        if (offer) begin
          in_bus.opcode          <= cur_cmd.opcode;
          in_bus.temp_sample     <= cur_cmd.temp;
          in_bus.hum_sample      <= cur_cmd.hum;
          in_bus.flag_value      <= cur_cmd.flag;
          in_bus.force_immediate <= cur_cmd.force_imm;
          in_bus.relay_sense     <= cur_cmd.sense;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // long receiver hold-off, so the command queue fills and in ready drops
  // ---------------------------------------------------------------------------
  int   run_cyc = 0;
  logic hold_off = 1'b0;

  always @(posedge clk) begin : holdoff_timer
    if (!rst_n) begin
      run_cyc  <= 0;
      hold_off <= 1'b0;
    end else begin
      run_cyc  <= run_cyc + 1;
      // a recurring hold-off window, so some fall inside busy phases
      hold_off <= ((run_cyc % 1500) >= 700) && ((run_cyc % 1500) < 1000);
    end
  end

  // ---------------------------------------------------------------------------
  // status monitor and receiver stall pattern
  // ---------------------------------------------------------------------------
  int stall_mode = 0;
  int mode_left  = 0;
  int beat       = 0;

  task automatic check_field(input string name, input logic [ERR_W-1:0] want,
                             input logic [ERR_W-1:0] got);
    if (got !== want) begin
      $error("status field %s: expected %0h, got %0h", name, want, got);
      fail_cnt++;
    end
  endtask

  always @(posedge clk) begin : status_monitor
    zone_status_t want;
    logic         take;
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (status_q.size() == 0) begin
          $error("status transfer with no command waiting for it");
          fail_cnt++;
        end else begin
          want = status_q.pop_front();
          check_field("relay_on", ERR_W'(want.relay_on), ERR_W'(out_bus.relay_on));
          check_field("relay_level", ERR_W'(want.relay_level), ERR_W'(out_bus.relay_level));
          check_field("failsafe_active", ERR_W'(want.failsafe_active),
                      ERR_W'(out_bus.failsafe_active));
          check_field("manual_active", ERR_W'(want.manual_active),
                      ERR_W'(out_bus.manual_active));
          check_field("force_off_active", ERR_W'(want.force_off_active),
                      ERR_W'(out_bus.force_off_active));
          check_field("reading_valid", ERR_W'(want.reading_valid),
                      ERR_W'(out_bus.reading_valid));
          check_field("error_count", want.error_count, out_bus.error_count);
          check_field("stuck_count", ERR_W'(want.stuck_count), ERR_W'(out_bus.stuck_count));
          check_field("switch_suppressed", ERR_W'(want.switch_suppressed),
                      ERR_W'(out_bus.switch_suppressed));
          check_field("temp_now", ERR_W'(want.temp_now), ERR_W'(out_bus.temp_now));
          check_field("hum_now", ERR_W'(want.hum_now), ERR_W'(out_bus.hum_now));
        end
      end
      // switch between always ready, light, periodic and heavy stalling
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(40, 200);
      end else begin
        mode_left--;
      end
      beat++;
      case (stall_mode)
        0:       take = 1'b1;
        1:       take = ($urandom_range(0, 3) != 0);
        2:       take = (beat % 5 != 4);
        default: take = ($urandom_range(0, 2) == 0);
      endcase
      out_bus.ready <= take && !hold_off;
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog
  // ---------------------------------------------------------------------------
  int cyc_cnt = 0;

  always @(posedge clk) begin : watchdog
    cyc_cnt <= cyc_cnt + 1;
    if (cyc_cnt == CYCLE_LIMIT) begin
      $display("hysteresis_relay_zone_controller verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus sequence
  // ---------------------------------------------------------------------------
  initial begin
    cfg_bus.valid          <= 1'b0;
    cfg_bus.index          <= REG_TEMP_THR;
    cfg_bus.data           <= '0;
    rst_n = 1'b0;

    thr_temp        = RST_TEMP_THR;
    thr_hum         = RST_HUM_THR;
    hyst_temp       = RST_TEMP_HYST;
    hyst_hum        = RST_HUM_HYST;
    min_hyst_temp   = RST_MIN_T_HYST;
    min_hyst_hum    = RST_MIN_H_HYST;
    min_switch_ms   = RST_MIN_SW_MS;
    relay           = 1'b0;
    manual          = 1'b0;
    forceoff        = 1'b0;
    failsafe        = 1'b0;
    seen_sample     = 1'b0;
    temp_held       = '0;
    hum_held        = '0;
    sensor_errs     = '0;
    stuck_run       = '0;
    ms_since_switch = '0;
    has_switched    = 1'b0;
    cfg_junk        = 1'b0;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed walk through the decision logic with reset register values
    cmd_q.push_back(make_cmd(OP_EVALUATE, 0, 0, 0, 0, 1));     // no sample yet, no demand
    cmd_q.push_back(make_cmd(OP_EVALUATE, 0, 0, 0, 1, 0));     // sense mismatch
    cmd_q.push_back(make_cmd(OP_SENSOR_ERROR, 0, 0, 0, 0, 0));
    cmd_q.push_back(make_cmd(OP_SAMPLE, 1250, 0, 0, 0, 0));    // clears error count
    cmd_q.push_back(make_cmd(OP_EVALUATE, 0, 0, 0, 0, 0));     // first switch, no interval
    cmd_q.push_back(make_cmd(OP_SAMPLE, -400, 1000, 0, 0, 0));
    cmd_q.push_back(make_cmd(OP_EVALUATE, 0, 0, 0, 0, 0));     // held on by humidity
    cmd_q.push_back(make_cmd(OP_SAMPLE, -400, 0, 0, 0, 0));
    cmd_q.push_back(make_cmd(OP_EVALUATE, 0, 0, 0, 0, 0));     // off blocked by interval
    cmd_q.push_back(make_cmd(OP_TICK, 0, 0, 0, 0, 0));
    cmd_q.push_back(make_cmd(OP_EVALUATE, 0, 0, 0, 1, 1));     // immediate switch off
    cmd_q.push_back(make_cmd(OP_SET_MANUAL, 0, 0, 1, 0, 0));
    cmd_q.push_back(make_cmd(OP_EVALUATE, 0, 0, 0, 0, 0));     // manual bypasses interval
    cmd_q.push_back(make_cmd(OP_SET_FORCEOFF, 0, 0, 1, 0, 0));
    cmd_q.push_back(make_cmd(OP_EVALUATE, 0, 0, 0, 0, 1));     // force-off beats manual
    cmd_q.push_back(make_cmd(OP_SET_FORCEOFF, 0, 0, 0, 0, 0));
    cmd_q.push_back(make_cmd(OP_FAILSAFE_ON, 0, 0, 0, 0, 0));
    cmd_q.push_back(make_cmd(OP_EVALUATE, 0, 0, 0, 0, 0));     // failsafe, no stuck check
    cmd_q.push_back(make_cmd(OP_FAILSAFE_OFF, 0, 0, 0, 0, 0));
    cmd_q.push_back(make_cmd(OP_EMERGENCY, 0, 0, 0, 0, 0));
    cmd_q.push_back(make_cmd(OPC_FIRST_UNUSED, 0, 0, 1, 1, 1));
    cmd_q.push_back(make_cmd(OPC_LAST_UNUSED, -1, 1023, 1, 1, 1));
    cmd_q.push_back(make_cmd(OP_SAMPLE, -2048, 1023, 0, 0, 0)); // out-of-range samples
    cmd_q.push_back(make_cmd(OP_SAMPLE, 2047, 0, 0, 0, 0));
    cmd_q.push_back(make_cmd(OP_EVALUATE, 0, 0, 0, 0, 1));
    wait_drained();

    // lowest register values: no interval at all, zero bands
    program_setting(-400, 0, 0, 0, 0, 0, 0);
    queue_random_phase(ITEMS_PER_PHASE);
    wait_drained();

    // highest in-range values, longest interval
    program_setting(1250, 1000, 500, 500, 100, 100, MS_W'(MS_MAX));
    queue_random_phase(ITEMS_PER_PHASE);
    wait_drained();

    // reset-like thresholds with a short interval so ticks cross it
    program_setting(300, 700, 10, 50, 5, 20, 25);
    queue_random_phase(ITEMS_PER_PHASE);
    wait_drained();

    // stuck counter saturation: thresholds out of reach keep the relay off, sense stuck
    // low; then a short run of sensor errors cleared by a sample
    program_setting(2047, 1023, 10, 10, 5, 5, 100);
    cmd_q.push_back(make_cmd(OP_EMERGENCY, 0, 0, 0, 0, 0));
    cmd_q.push_back(make_cmd(OP_SAMPLE, -2048, 0, 0, 0, 0));
    repeat (STUCK_MAX + 5) cmd_q.push_back(make_cmd(OP_EVALUATE, 0, 0, 0, 0, 0));
    cmd_q.push_back(make_cmd(OP_EVALUATE, 0, 0, 0, 0, 1));
    repeat (20) cmd_q.push_back(noisy_cmd(OP_SENSOR_ERROR));
    cmd_q.push_back(make_cmd(OP_SAMPLE, 0, 0, 0, 0, 0));
    wait_drained();

    // raw register extremes beyond the nominal ranges
    program_setting(2047, 1023, 511, 3, 127, 0, 7);
    queue_random_phase(ITEMS_PER_PHASE);
    wait_drained();
    program_setting(-2048, 0, 0, 511, 0, 127, 3);
    queue_random_phase(ITEMS_PER_PHASE);
    wait_drained();

    // random settings with short intervals
    repeat (2) begin
      program_setting(TEMP_W'(int'($urandom_range(0, 1650)) - 400),
                      HUM_W'($urandom_range(0, 1000)), HYST_W'($urandom_range(0, 511)),
                      HYST_W'($urandom_range(0, 511)), MINH_W'($urandom_range(0, 127)),
                      MINH_W'($urandom_range(0, 127)), MS_W'($urandom_range(0, 60)));
      queue_random_phase(ITEMS_PER_PHASE / 2);
      wait_drained();
    end

    // let any stray status transfer show up before the verdict
    repeat (10) @(posedge clk);
    if (fail_cnt == 0 && status_q.size() == 0) begin
      $display("hysteresis_relay_zone_controller verification clean");
    end else begin
      $display("hysteresis_relay_zone_controller verification failed");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+hdl
hdl/hrzc_pkg.sv
hdl/hrzc_ifs.sv
hdl/hrzc_front.sv
hdl/hrzc_queue.sv
hdl/hrzc_back.sv
hdl/hysteresis_relay_zone_controller.sv
sim/hysteresis_relay_zone_controller_tb.sv
